### src/lfbs_pkg.sv
// Shared types, constants and pixel arithmetic for the LED frame-buffer serialiser.
package lfbs_pkg;

  localparam int PIXELS_DEF = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SHIFT  = 1'd1;

  localparam logic [3:0] FADE_SHIFT_RST = 4'd3;
  localparam logic [7:0] CHAN_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_ADD   = 3'd1,
    OP_FADE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_SYNC  = 3'd4,
    OP_START = 3'd5,
    OP_TICK  = 3'd6
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted word, clear result flags
    logic rng_init;     // set up the range walk
    logic rng_step;     // read one pixel of the range, advance the address
    logic set_sync;     // arm a frame
    logic frame_open;   // open a frame and count it
    logic frame_close;  // end the frame, disarm the sync
    logic tick_read;    // read the pixel holding the current bit
    logic tick_bit;     // emit the bit and advance the bit position
    logic respond;      // register the result word
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic range_hit;
    logic rng_last;
    logic can_start;
    logic tick_emit;
    logic tick_end;
  } dp_stat_t;

  function automatic logic [7:0] add_half(input logic [7:0] p, input logic [7:0] c);
    logic [8:0] s;
    s = {1'b0, p} + {2'b0, c[7:1]};
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] fade_chan(input logic [7:0] p, input logic [3:0] k);
    logic [22:0] w;
    w = ({15'b0, p} << k) - {15'b0, p};
    return 8'(w >> k);
  endfunction

endpackage

### src/lfbs_dp.sv
// Datapath: configuration, pixel store, range walk, frame and bit counters, result word.
module lfbs_dp #(
  parameter int PIXELS = lfbs_pkg::PIXELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lfbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [2:0]                       in_operation,
  input  logic [7:0]                       in_start_index,
  input  logic [7:0]                       in_count,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  input  lfbs_pkg::dp_cmd_t                cmd,
  output lfbs_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  output logic                             out_ready_res,
  output logic                             out_bit_valid,
  output logic                             out_bit_value,
  output logic                             out_frame_done,
  output logic [15:0]                      out_frames_sent
);
  import lfbs_pkg::*;

  localparam int NW = $clog2(PIXELS + 1);
  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Configuration
  logic [6:0]    pixel_count_r;
  logic [3:0]    fade_shift_r;

  // Captured command word
  op_t           op_r;
  logic [7:0]    first_r;
  logic [7:0]    cnt_r;
  logic [7:0]    red_r, green_r, blue_r;

  // Frame state
  logic          sync_r;
  logic          sending_r;
  logic [15:0]   frames_r;
  logic [NW-1:0] pix_r;
  logic [1:0]    byte_r;
  logic [2:0]    bit_r;

  // Range walk and read-modify-write pipeline
  logic [NW-1:0] addr_r;
  logic [NW-1:0] end_r;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;

  // Pixel store: {red, green, blue}, with a valid bit per entry so that
  // an entry never written since reset reads as black.
  logic [23:0]   mem [PIXELS];
  logic [PIXELS-1:0] vld_r;
  logic [23:0]   rd_data_r;
  logic          rd_vld_r;

  // Result flags
  logic          bv_r, bval_r, done_r;
  logic          out_valid_r, ready_r, bv_out_r, bval_out_r, done_out_r;
  logic [15:0]   frames_out_r;

  logic [NW-1:0] n;
  logic [8:0]    n9;
  logic [8:0]    sum9;
  logic [NW-1:0] end_nxt;
  logic [3:0]    k;
  logic [23:0]   rd_pix;
  logic [23:0]   wr_pix_nxt;
  logic [AW-1:0] rd_addr;
  logic [7:0]    sel_byte;
  logic [2:0]    bit_sel;
  logic          bval_nxt;

  always_comb begin
    if ({2'b0, pixel_count_r} > 9'(PIXELS)) begin
      n = NW'(PIXELS);
    end else begin
      n = NW'(pixel_count_r);
    end
    n9   = 9'(n);
    sum9 = {1'b0, first_r} + {1'b0, cnt_r};
    if (sum9 > n9) begin
      end_nxt = n;
    end else begin
      end_nxt = NW'(sum9);
    end
    k = (fade_shift_r == 4'd0) ? 4'd1 : fade_shift_r;
  end

  always_comb begin
    stat.op        = op_r;
    stat.range_hit = ({1'b0, first_r} < n9) && (cnt_r != 8'd0);
    stat.rng_last  = ({1'b0, addr_r} + 1'b1) == {1'b0, end_r};
    stat.can_start = (n != '0) && !sending_r && sync_r;
    stat.tick_emit = sending_r && (pix_r < n);
    stat.tick_end  = sending_r && !(pix_r < n);
  end

  assign rd_pix = rd_vld_r ? rd_data_r : 24'd0;

  always_comb begin
    case (op_r)
      OP_SET:  wr_pix_nxt = {red_r, green_r, blue_r};
      OP_ADD:  wr_pix_nxt = {add_half(rd_pix[23:16], red_r),
                             add_half(rd_pix[15:8], green_r),
                             add_half(rd_pix[7:0], blue_r)};
      OP_FADE: wr_pix_nxt = {fade_chan(rd_pix[23:16], k),
                             fade_chan(rd_pix[15:8], k),
                             fade_chan(rd_pix[7:0], k)};
      default: wr_pix_nxt = 24'd0;
    endcase
  end

  // Wire order is green, red, blue, each most significant bit first.
  always_comb begin
    case (byte_r)
      2'd0:    sel_byte = rd_pix[15:8];
      2'd1:    sel_byte = rd_pix[23:16];
      default: sel_byte = rd_pix[7:0];
    endcase
    bit_sel  = 3'd7 - bit_r;
    bval_nxt = sel_byte[bit_sel];
  end

  assign rd_addr = cmd.rng_step ? addr_r[AW-1:0] : pix_r[AW-1:0];

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_addr_r] <= wr_pix_nxt;
    end
    if (cmd.rng_step || cmd.tick_read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_pend_r) begin
        vld_r[wr_addr_r] <= 1'b1;
      end
      if (cmd.rng_step || cmd.tick_read) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Captured word and range addresses carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      first_r <= in_start_index;
      cnt_r   <= in_count;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (cmd.rng_init) begin
      addr_r <= NW'(first_r);
      end_r  <= end_nxt;
    end else if (cmd.rng_step) begin
      addr_r <= addr_r + 1'b1;
    end
    if (cmd.rng_step) begin
      wr_addr_r <= addr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= 7'd0;
      fade_shift_r  <= FADE_SHIFT_RST;
      sync_r        <= 1'b0;
      sending_r     <= 1'b0;
      frames_r      <= 16'd0;
      pix_r         <= '0;
      byte_r        <= 2'd0;
      bit_r         <= 3'd0;
      wr_pend_r     <= 1'b0;
      bv_r          <= 1'b0;
      bval_r        <= 1'b0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PIXEL_COUNT: pixel_count_r <= cfg_data;
          REG_FADE_SHIFT:  fade_shift_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      wr_pend_r   <= cmd.rng_step;
      out_valid_r <= cmd.respond;
      if (cmd.load) begin
        bv_r   <= 1'b0;
        bval_r <= 1'b0;
        done_r <= 1'b0;
      end
      if (cmd.set_sync) begin
        sync_r <= 1'b1;
      end
      if (cmd.frame_open) begin
        sending_r <= 1'b1;
        frames_r  <= frames_r + 16'd1;
        pix_r     <= '0;
        byte_r    <= 2'd0;
        bit_r     <= 3'd0;
      end
      if (cmd.frame_close) begin
        sending_r <= 1'b0;
        sync_r    <= 1'b0;
        done_r    <= 1'b1;
      end
      if (cmd.tick_bit) begin
        bv_r   <= 1'b1;
        bval_r <= bval_nxt;
        bit_r  <= bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          if (byte_r == 2'd2) begin
            byte_r <= 2'd0;
            pix_r  <= pix_r + 1'b1;
          end else begin
            byte_r <= byte_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      ready_r      <= !sync_r && !sending_r;
      bv_out_r     <= bv_r;
      bval_out_r   <= bval_r;
      done_out_r   <= done_r;
      frames_out_r <= frames_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ready_res   = ready_r;
  assign out_bit_valid   = bv_out_r;
  assign out_bit_value   = bval_out_r;
  assign out_frame_done  = done_out_r;
  assign out_frames_sent = frames_out_r;

endmodule

### src/lfbs_ctrl.sv
// Controller: sequences each accepted command word through the datapath.
module lfbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lfbs_pkg::dp_stat_t stat,
  output lfbs_pkg::dp_cmd_t  cmd
);
  import lfbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RANGE,
    S_RANGE_END,
    S_TICK,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESP;
        case (stat.op)
          OP_SET, OP_ADD, OP_FADE, OP_CLEAR: begin
            if (stat.range_hit) begin
              cmd.rng_init = 1'b1;
              state_nxt    = S_RANGE;
            end
          end
          OP_SYNC:  cmd.set_sync = 1'b1;
          OP_START: cmd.frame_open = stat.can_start;
          OP_TICK: begin
            if (stat.tick_emit) begin
              cmd.tick_read = 1'b1;
              state_nxt     = S_TICK;
            end else begin
              cmd.frame_close = stat.tick_end;
            end
          end
          default: ;
        endcase
      end
      S_RANGE: begin
        cmd.rng_step = 1'b1;
        if (stat.rng_last) begin
          state_nxt = S_RANGE_END;
        end
      end
      S_RANGE_END: state_nxt = S_RESP;
      S_TICK: begin
        cmd.tick_bit = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### src/led_framebuffer_serializer.sv
// Top level of the LED frame-buffer serialiser: controller plus datapath.
// Sync, start, a refused command and the frame-ending tick go from decode straight to the result;
// a tick that emits a bit reads the store first, and a range walk steps through its pixels.
// A new word is taken only while busy is low, and the receiver cannot hold a result off.
// Reset (rst_n low at a clock edge) clears every pixel to black at once, disarms the sync,
// closes any frame, zeroes the frame counter and sets pixel count 0 and fade strength 3.
module led_framebuffer_serializer #(
  parameter int PIXELS = lfbs_pkg::PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_wr_en,
  input  logic [lfbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // Command word
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_operation,
  input  logic [7:0]                      in_start_index,
  input  logic [7:0]                      in_count,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  // Result word, valid for exactly one cycle
  output logic                            out_valid,
  output logic                            out_ready_res,
  output logic                            out_bit_valid,
  output logic                            out_bit_value,
  output logic                            out_frame_done,
  output logic [15:0]                     out_frames_sent
);
  import lfbs_pkg::*;

  // The controller steps through decode, the range walk or the store read for a bit, and
  // finally registers the result word. The datapath owns every register that carries
  // data: configuration, the pixel store with its per-entry valid bits, the frame state
  // and the position of the next bit, kept as pixel, byte and bit counters so that no
  // division by 24 is needed. A range walk reads and rewrites one pixel a cycle, and busy
  // stays high until the result word is registered.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  lfbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // A pixel count beyond the store size is clipped to PIXELS inside the datapath; a
  // frame lasts as long as the current count says, so it follows later changes.
  lfbs_dp #(
    .PIXELS (PIXELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_operation    (in_operation),
    .in_start_index  (in_start_index),
    .in_count        (in_count),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready_res   (out_ready_res),
    .out_bit_valid   (out_bit_valid),
    .out_bit_value   (out_bit_value),
    .out_frame_done  (out_frame_done),
    .out_frames_sent (out_frames_sent)
  );

endmodule
